// ===== hw/rtl/rtpd_pkg.sv =====
package rtpd_pkg;

	localparam int MAX_PACKET_BYTES  = 65535;
	localparam int FIXED_HDR_BYTES   = 12;
	localparam int POS_W             = $clog2(MAX_PACKET_BYTES + 1);
	localparam int EXT_W             = 18;

	// Result queue: deep enough to take a data word and a summary in the same cycle
	// while earlier words still wait for the receiver.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [2:0] KIND_PAY     = 3'd0;
	localparam logic [2:0] KIND_XDATA   = 3'd1;
	localparam logic [2:0] KIND_CSRC    = 3'd2;
	localparam logic [2:0] KIND_SUMMARY = 3'd3;
	localparam logic [2:0] KIND_XHDR    = 3'd4;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
	localparam logic [1:0] STATUS_BAD_PAD   = 2'd2;

	typedef enum logic [2:0] {
		PH_HDR   = 3'd0,
		PH_CSRC  = 3'd1,
		PH_XHDR  = 3'd2,
		PH_XDATA = 3'd3,
		PH_PAY   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [31:0] data_word;
		logic [1:0]  version;
		logic        marker;
		logic [6:0]  payload_type;
		logic [15:0] sequence_number;
		logic [31:0] timestamp;
		logic [31:0] ssrc;
		logic [3:0]  csrc_count;
		logic        extension_present;
		logic [7:0]  trim_count;
		logic [1:0]  status;
	} result_t;

	// Words handed from the parser to the result queue in the same cycle.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

// ===== hw/rtl/rtpd_parser.sv =====
module rtpd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output rtpd_pkg::push_t      push
);
	import rtpd_pkg::*;

	typedef struct packed {
		phase_t             phase;
		logic [POS_W-1:0]   pos;
		logic [7:0]         first_octet;
		logic [7:0]         second_octet;
		logic [15:0]        seq;
		logic [31:0]        ts;
		logic [31:0]        ssrc;
		logic [31:0]        word_shift;
		logic [3:0]         csrc_rem;
		logic [EXT_W-1:0]   ext_rem;
		logic [15:0]        pay_count;
	} st_t;

	localparam st_t ST_RESET = '{phase: PH_HDR, default: '0};
	localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_PACKET_BYTES);
	localparam logic [POS_W-1:0] POS_HEND = POS_W'(FIXED_HDR_BYTES - 1);

	st_t     cur_q;
	st_t     nxt;
	result_t data_res;
	result_t summ_res;
	logic    data_v;

	always_comb begin
		nxt      = cur_q;
		data_v   = 1'b0;
		data_res = '0;
		summ_res = '0;
		if (go && (cur_q.pos < POS_MAX)) begin
			nxt.word_shift = {cur_q.word_shift[23:0], data_byte};
			case (cur_q.phase)
				PH_HDR: begin
					if (cur_q.pos == POS_W'(0))
						nxt.first_octet = data_byte;
					else if (cur_q.pos == POS_W'(1))
						nxt.second_octet = data_byte;
					else if (cur_q.pos < POS_W'(4))
						nxt.seq = {cur_q.seq[7:0], data_byte};
					else if (cur_q.pos < POS_W'(8))
						nxt.ts = {cur_q.ts[23:0], data_byte};
					else
						nxt.ssrc = {cur_q.ssrc[23:0], data_byte};
					if (cur_q.pos == POS_HEND) begin
						nxt.csrc_rem = cur_q.first_octet[3:0];
						if (cur_q.first_octet[3:0] != 4'd0)
							nxt.phase = PH_CSRC;
						else
							nxt.phase = cur_q.first_octet[4] ? PH_XHDR : PH_PAY;
					end
				end
				PH_CSRC: begin
					if (cur_q.pos[1:0] == 2'b11) begin
						data_v = 1'b1;
						data_res.result_kind = KIND_CSRC;
						data_res.data_word = nxt.word_shift;
						nxt.csrc_rem = cur_q.csrc_rem - 4'd1;
						if (nxt.csrc_rem == 4'd0)
							nxt.phase = cur_q.first_octet[4] ? PH_XHDR : PH_PAY;
					end
				end
				PH_XHDR: begin
					if (cur_q.pos[1:0] == 2'b11) begin
						data_v = 1'b1;
						data_res.result_kind = KIND_XHDR;
						data_res.data_word = nxt.word_shift;
						nxt.ext_rem = {nxt.word_shift[15:0], 2'b00};
						nxt.phase = (nxt.word_shift[15:0] != 16'd0) ? PH_XDATA : PH_PAY;
					end
				end
				PH_XDATA: begin
					data_v = 1'b1;
					data_res.result_kind = KIND_XDATA;
					data_res.data_word = {24'd0, data_byte};
					nxt.ext_rem = cur_q.ext_rem - EXT_W'(1);
					if (nxt.ext_rem == '0)
						nxt.phase = PH_PAY;
				end
				default: begin
					data_v = 1'b1;
					data_res.result_kind = KIND_PAY;
					data_res.data_word = {24'd0, data_byte};
					nxt.pay_count = cur_q.pay_count + 16'd1;
				end
			endcase
			nxt.pos = cur_q.pos + POS_W'(1);
		end

		// The summary reflects the state after this byte has been parsed.
		summ_res.result_kind       = KIND_SUMMARY;
		summ_res.version           = nxt.first_octet[7:6];
		summ_res.marker            = nxt.second_octet[7];
		summ_res.payload_type      = nxt.second_octet[6:0];
		summ_res.sequence_number   = nxt.seq;
		summ_res.timestamp         = nxt.ts;
		summ_res.ssrc              = nxt.ssrc;
		summ_res.csrc_count        = nxt.first_octet[3:0];
		summ_res.extension_present = nxt.first_octet[4];
		if (nxt.phase != PH_PAY)
			summ_res.status = STATUS_TRUNCATED;
		else if (nxt.first_octet[5]) begin
			if ({8'd0, data_byte} > nxt.pay_count)
				summ_res.status = STATUS_BAD_PAD;
			else
				summ_res.trim_count = data_byte;
		end

		if (go && last_byte)
			nxt = ST_RESET;

		push.first  = data_v ? data_res : summ_res;
		push.second = summ_res;
		push.count  = go ? ({1'b0, data_v} + {1'b0, last_byte}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cur_q <= ST_RESET;
		else
			cur_q <= nxt;
	end

endmodule

// ===== hw/rtl/rtpd_out_fifo.sv =====
module rtpd_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  rtpd_pkg::push_t   push,
	input  logic              pop,
	output logic              room,
	output logic              not_empty,
	output rtpd_pkg::result_t head
);
	import rtpd_pkg::*;

	result_t          mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] count_q;

	// Room means two free entries, so a data word and a summary always fit.
	assign room      = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wp_q] <= push.first;
		if (push.count == 2'd2)
			mem_q[wp_q + PTR_W'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PTR_W'(push.count);
			rp_q    <= rp_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule

// ===== hw/rtl/rtp_packet_deframer_top.sv =====
// RTP packet deframer.
// Packet bytes enter on the byte channel (data_byte, last_byte, byte_valid,
// byte_stall), one byte per cycle while not stalled, in wire order, the final
// byte of each packet carrying last_byte. The fixed twelve-byte header is
// captured in network order; CSRC words, the extension header word, extension
// data bytes and payload bytes then leave on the result channel (result_valid,
// result_stall) as separate words; the final byte adds a packet summary word.
// A byte accepted on the byte channel is held in an input register, then
// parsed into a four-entry result queue once the queue has room, and its
// result words are offered from the head of the queue.
// Throughput is one byte per cycle while the result queue has room; the
// summary word that each packet adds is absorbed by the result queue.
// The byte channel stalls only when the result queue has fewer than two free
// entries, so a stalled receiver backs the stall up to the sender after the
// queue and the input register have filled; no word is lost or repeated.
// Asynchronous reset clears the parser to the start of a packet and empties
// the queue; the parser also returns to that state after every summary.
module rtp_packet_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        byte_valid,
	output logic        byte_stall,
	output logic [2:0]  result_kind,
	output logic [31:0] data_word,
	output logic [1:0]  version,
	output logic        marker,
	output logic [6:0]  payload_type,
	output logic [15:0] sequence_number,
	output logic [31:0] timestamp,
	output logic [31:0] ssrc,
	output logic [3:0]  csrc_count,
	output logic        extension_present,
	output logic [7:0]  trim_count,
	output logic [1:0]  status,
	output logic        result_valid,
	input  logic        result_stall
);
	import rtpd_pkg::*;

	logic    valid_s1;
	logic    last_s1;
	logic [7:0] byte_s1;
	logic    room;
	logic    advance;
	logic    pop;
	push_t   push;
	result_t head;

	// The held byte moves on whenever the queue can take both of its words.
	assign advance    = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!byte_stall)
			valid_s1 <= byte_valid;
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	rtpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.push      (push)
	);

	assign pop = result_valid && !result_stall;

	rtpd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.room      (room),
		.not_empty (result_valid),
		.head      (head)
	);

	assign result_kind       = head.result_kind;
	assign data_word         = head.data_word;
	assign version           = head.version;
	assign marker            = head.marker;
	assign payload_type      = head.payload_type;
	assign sequence_number   = head.sequence_number;
	assign timestamp         = head.timestamp;
	assign ssrc              = head.ssrc;
	assign csrc_count        = head.csrc_count;
	assign extension_present = head.extension_present;
	assign trim_count        = head.trim_count;
	assign status            = head.status;

endmodule
